// File: rtl/periodic_poll_scheduler_assert.svh
// Assertion macros shared by the periodic poll scheduler RTL.
// Bodies are empty when SYNTHESIS is defined; no other dependencies.
`ifndef PERIODIC_POLL_SCHEDULER_ASSERT_SVH
`define PERIODIC_POLL_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset
`define PPS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define PPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPS_ASSERT(label, clk, rstn, prop, msg)
`define PPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/pps_pkg.sv
// Shared types and constants of the periodic poll scheduler.
// Used by pps_ctrl, pps_dp and the top level; no dependencies.
`default_nettype none

package pps_pkg;

    // Opcodes carried on s_tuser
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_MARK = 2'd2;

    // Field widths
    localparam int OP_W      = 2;
    localparam int PERIOD_W  = 32;
    localparam int IDX_W     = 3;
    localparam int ELAPSED_W = 16;
    localparam int TIME_W    = 48;
    localparam int WAIT_W    = 27;
    localparam int MASK_W    = 8;
    localparam int USED_W    = 4;

    // Bus widths
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;

    // Wait constants
    localparam logic [WAIT_W-1:0] WAIT_EMPTY = 27'd1000;
    localparam logic [WAIT_W-1:0] WAIT_FLOOR = 27'd100;
    localparam logic [WAIT_W-1:0] WAIT_CAP   = 27'd86400000;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture input word
        logic apply;     // apply add or tick, arm the scan
        logic mark_rd;   // read period of marked entry
        logic mark_wr;   // write new deadline of marked entry
        logic scan_run;  // step the deadline scan
        logic emit;      // load result into output register
    } pps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_mark;  // mark read op with index inside count
        logic scan_done;  // all held entries checked
        logic out_free;   // output register can take a word
    } pps_sts_t;

endpackage

`default_nettype wire

// File: rtl/pps_dp.sv
// Datapath of the periodic poll scheduler: time counter, entry count,
// deadline and period memories, scan unit and output register. Uses pps_pkg.
`default_nettype none
`include "periodic_poll_scheduler_assert.svh"

module pps_dp #(
    parameter int ENTRIES = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [pps_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [pps_pkg::S_USER_W-1:0]  s_tuser,
    input  wire pps_pkg::pps_cmd_t             cmd,
    output pps_pkg::pps_sts_t                  sts,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pps_pkg::M_DATA_W-1:0]       m_tdata
);
    import pps_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    // Captured input word
    logic [OP_W-1:0]      op_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;

    // Scheduler state
    logic [TIME_W-1:0] time_reg;
    logic [CW-1:0]     count_reg;
    logic              reject_reg;

    // Entry memories
    logic [TIME_W-1:0]   deadline_mem [ENTRIES];
    logic [PERIOD_W-1:0] period_mem   [ENTRIES];
    logic [TIME_W-1:0]   dl_rd_reg;
    logic [PERIOD_W-1:0] per_rd_reg;

    // Scan unit
    logic [CW-1:0]     scan_addr_reg;
    logic              chk_valid_reg;
    logic [CW-1:0]     chk_idx_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [WAIT_W-1:0] best_reg;

    // Output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic              add_ok;
    logic              mark_ok;
    logic              scan_more;
    logic              add_wr;
    logic              dl_we;
    logic [IW-1:0]     dl_waddr;
    logic [TIME_W-1:0] dl_wdata;
    logic [TIME_W:0]   diff;
    logic              due;
    logic [WAIT_W-1:0] wait_val;

    // Status decode
    assign add_ok    = (count_reg != FULL);
    assign mark_ok   = (CMPW'(idx_reg) < CMPW'(count_reg));
    assign scan_more = (scan_addr_reg != count_reg);

    always_comb begin
        sts.need_mark = (op_reg == OP_MARK) && mark_ok;
        sts.scan_done = !scan_more && !chk_valid_reg;
        sts.out_free  = !m_valid_reg || m_tready;
    end

    // Input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg      <= s_tuser[OP_W-1:0];
            period_reg  <= s_tdata[PERIOD_W-1:0];
            idx_reg     <= s_tdata[PERIOD_W +: IDX_W];
            elapsed_reg <= s_tdata[PERIOD_W+IDX_W +: ELAPSED_W];
        end
    end

    // Time counter, entry count, reject flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.apply) begin
            if (op_reg == OP_ADD && add_ok) begin
                count_reg <= count_reg + CW'(1);
            end
            if (op_reg == OP_TICK) begin
                time_reg <= time_reg + TIME_W'(elapsed_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            reject_reg <= (op_reg == OP_ADD) && !add_ok;
        end
    end

    // Memory write port: add appends, mark read rewrites one deadline
    assign add_wr   = cmd.apply && (op_reg == OP_ADD) && add_ok;
    assign dl_we    = add_wr || cmd.mark_wr;
    assign dl_waddr = cmd.mark_wr ? IW'(idx_reg) : count_reg[IW-1:0];
    assign dl_wdata = cmd.mark_wr ? (time_reg + TIME_W'(per_rd_reg)) : time_reg;

    always_ff @(posedge aclk) begin
        if (dl_we) begin
            deadline_mem[dl_waddr] <= dl_wdata;
        end
        if (add_wr) begin
            period_mem[count_reg[IW-1:0]] <= period_reg;
        end
    end

    // Registered reads
    always_ff @(posedge aclk) begin
        if (cmd.mark_rd) begin
            per_rd_reg <= period_mem[IW'(idx_reg)];
        end
        if (cmd.scan_run && scan_more) begin
            dl_rd_reg <= deadline_mem[scan_addr_reg[IW-1:0]];
        end
    end

    // Scan control: one address issued per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
        end else if (cmd.apply) begin
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
        end else if (cmd.scan_run) begin
            chk_valid_reg <= scan_more;
            if (scan_more) begin
                scan_addr_reg <= scan_addr_reg + CW'(1);
            end
        end
    end

    // Gap to deadline; a borrow or zero means the entry is due
    assign diff = {1'b0, dl_rd_reg} - {1'b0, time_reg};
    assign due  = diff[TIME_W] || (diff[TIME_W-1:0] == '0);

    // Due mask and earliest gap
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            mask_reg <= '0;
            best_reg <= WAIT_CAP;
        end else begin
            if (cmd.scan_run && scan_more) begin
                chk_idx_reg <= scan_addr_reg;
            end
            if (chk_valid_reg) begin
                if (due) begin
                    mask_reg <= mask_reg | (MASK_W'(1) << chk_idx_reg);
                    best_reg <= '0;
                end else if (!(|diff[TIME_W-1:WAIT_W])
                             && (diff[WAIT_W-1:0] < best_reg)) begin
                    best_reg <= diff[WAIT_W-1:0];
                end
            end
        end
    end

    // Final wait value
    always_comb begin
        if (count_reg == '0) begin
            wait_val = WAIT_EMPTY;
        end else if (best_reg < WAIT_FLOOR) begin
            wait_val = WAIT_FLOOR;
        end else begin
            wait_val = best_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {reject_reg, USED_W'(count_reg), wait_val, mask_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    `PPS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= FULL, "entry count above table size")
    `PPS_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_valid_reg, "emitted word not valid")
    `PPS_ASSERT_NEXT(a_reject_hold, aclk, aresetn, cmd.apply && (op_reg == OP_ADD) && !add_ok, $stable(count_reg), "rejected add changed count")

endmodule

`default_nettype wire

// File: rtl/pps_ctrl.sv
// Controller of the periodic poll scheduler: sequences apply, mark read,
// deadline scan and result emit. Uses pps_pkg.
`default_nettype none
`include "periodic_poll_scheduler_assert.svh"

module pps_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire pps_pkg::pps_sts_t  sts,
    output pps_pkg::pps_cmd_t       cmd
);
    import pps_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_APPLY   = 3'd1;
    localparam logic [2:0] ST_MARK_RD = 3'd2;
    localparam logic [2:0] ST_MARK_WR = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load_in  = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = sts.need_mark ? ST_MARK_RD : ST_SCAN;
            end
            ST_MARK_RD: begin
                cmd.mark_rd = 1'b1;
                state_next  = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                cmd.mark_wr = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Checks
    `PPS_ASSERT(a_emit_free, aclk, aresetn, !cmd.emit || sts.out_free, "emit into full output register")
    `PPS_ASSERT_NEXT(a_accept_apply, aclk, aresetn, accept, state_reg == ST_APPLY, "accepted word not applied")
    `PPS_ASSERT_NEXT(a_scan_emit, aclk, aresetn, (state_reg == ST_SCAN) && sts.scan_done, state_reg == ST_EMIT, "finished scan did not emit")

endmodule

`default_nettype wire

// File: rtl/periodic_poll_scheduler.sv
// Periodic poll scheduler: up to ENTRIES polling entries, each with a period
// and a next deadline, plus a millisecond time counter.
// s_tuser carries the op: add entry, advance time, or mark entry read.
// s_tdata carries period_ms, entry_index and elapsed_ms; each word returns one
// m_tdata word with due_mask, wait_ms, entries_used and add_rejected.
// One word is in flight at a time. From acceptance, the controller applies
// the op, does a period read and a deadline write for a mark read, then scans
// the deadline memory one entry per cycle through its registered read port,
// then loads the output register. The next word is taken once the result is
// loaded, so the deadline memory read port sets the pace. The result turns
// valid in the same cycle that s_tready rises again.
// The output register lets a new word be accepted and processed while the
// last result waits; a stalled m_tready holds the controller at result load.
// Reset (aresetn low, synchronous) clears the time counter, the entry count
// and both channels; entry memories are not cleared, as only held entries
// are read. Depends on pps_pkg, pps_ctrl, pps_dp.
`default_nettype none

module periodic_poll_scheduler #(
    parameter int ENTRIES = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: period_ms[31:0], entry_index[34:32], elapsed_ms[50:35], zero pad
    input  wire logic [pps_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [pps_pkg::S_USER_W-1:0]  s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // m_tdata: due_mask[7:0], wait_ms[34:8], entries_used[38:35], add_rejected[39]
    output logic [pps_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);
    import pps_pkg::*;

    pps_cmd_t cmd;
    pps_sts_t sts;

    // Sequencer
    pps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Tables, time, scan and output register
    pps_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
